// ----- hdl/i8085s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package i8085s_pkg;

    // Flag bit positions.
    localparam int FL_S  = 4;
    localparam int FL_Z  = 3;
    localparam int FL_AC = 2;
    localparam int FL_P  = 1;
    localparam int FL_CY = 0;

    // Opcodes with a fixed encoding.
    localparam logic [7:0] OP_ADI = 8'hC6;
    localparam logic [7:0] OP_ACI = 8'hCE;
    localparam logic [7:0] OP_ANI = 8'hE6;
    localparam logic [7:0] OP_CPI = 8'hFE;
    localparam logic [7:0] OP_CMA = 8'h2F;
    localparam logic [7:0] OP_CMC = 8'h3F;
    localparam logic [7:0] OP_DAA = 8'h27;
    localparam logic [7:0] OP_IN  = 8'hDB;
    localparam logic [7:0] OP_LDA = 8'h3A;
    localparam logic [7:0] OP_JMP = 8'hC3;
    localparam logic [7:0] OP_CALL = 8'hCD;
    localparam logic [7:0] OP_RET = 8'hC9;
    localparam logic [7:0] OP_HLT = 8'h76;

    // Register field codes.
    localparam logic [2:0] REG_M = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;
    localparam logic [1:0] RP_HL = 2'd2;
    localparam logic [1:0] RP_SP = 2'd3;

    // Accumulator unit function codes.
    localparam logic [1:0] FN_ADD = 2'd0;
    localparam logic [1:0] FN_AND = 2'd1;
    localparam logic [1:0] FN_CMP = 2'd2;
    localparam logic [1:0] FN_DAA = 2'd3;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] data_low;
        logic [7:0] data_high;
        logic [7:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  acc;
        logic [4:0]  flags;
        logic [15:0] hl_pair;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic        halted;
        logic        stack_error;
    } out_item_t;

    // Sign, zero and even parity flags of a result byte.
    function automatic logic [4:0] szp(input logic [7:0] v);
        logic [4:0] f;
        f = '0;
        f[FL_S] = v[7];
        f[FL_Z] = (v == 8'h00);
        f[FL_P] = ~^v;
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/i8085s_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic on the accumulator: add with carry, and, compare, decimal adjust.
module i8085s_alu
    import i8085s_pkg::*;
(
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    input  wire logic       cin,
    input  wire logic [4:0] flags_in,
    input  wire logic [1:0] func,
    output logic [7:0]      result,
    output logic [4:0]      flags_out
);

    logic [8:0] sum;
    logic [4:0] nib;
    logic [7:0] diff;
    logic [7:0] corr;
    logic       dcy;
    logic [8:0] dsum;

    always_comb begin
        sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        diff = a - b;
        corr = '0;
        dcy  = flags_in[FL_CY];
        if (flags_in[FL_AC] || a[3:0] > 4'd9) begin
            corr[3:0] = 4'h6;
        end
        if (flags_in[FL_CY] || a[7:4] > 4'd9 || (a[7:4] >= 4'd9 && a[3:0] > 4'd9)) begin
            corr[7:4] = 4'h6;
            dcy = 1'b1;
        end
        dsum = {1'b0, a} + {1'b0, corr};
        unique case (func)
            FN_ADD: begin
                result = sum[7:0];
                flags_out = szp(sum[7:0]);
                flags_out[FL_AC] = nib[4];
                flags_out[FL_CY] = sum[8];
            end
            FN_AND: begin
                result = a & b;
                flags_out = szp(a & b);
                flags_out[FL_AC] = 1'b1;
            end
            FN_CMP: begin
                result = a;
                flags_out = szp(diff);
                flags_out[FL_AC] = (a[3:0] >= b[3:0]);
                flags_out[FL_CY] = (a < b);
            end
            default: begin
                result = dsum[7:0];
                flags_out = szp(dsum[7:0]);
                flags_out[FL_AC] = ({1'b0, a[3:0]} + {1'b0, corr[3:0]}) > 5'h0F;
                flags_out[FL_CY] = dcy;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/i8085_subset_execute_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Executes one instruction of an 8085 subset per transaction. Each accepted
// item is decoded combinationally against the register file, flags, program
// counter and return stack; the result is registered and the next item can
// be accepted in the same cycle, so the unit sustains one instruction per
// clock while m_ready stays high. The result register holds while m_valid is
// high and m_ready is low; a new item is taken whenever that register is
// empty or being drained. Asserting cfg_we loads cfg_wdata into the program
// counter, taking priority over the update from an accepted instruction.
module i8085_subset_execute_unit
    import i8085s_pkg::*;
#(
    parameter int RETURN_DEPTH = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int DW = $clog2(RETURN_DEPTH + 1);
    localparam int AW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;

    logic [7:0]  a_reg, a_next;
    logic [7:0]  r_reg [6];
    logic [7:0]  r_next [6];
    logic [15:0] sp_reg, sp_next;
    logic [4:0]  f_reg, f_next;
    logic [15:0] pc_reg, pc_next;
    logic [DW-1:0] dep_reg, dep_next;
    logic        halt_reg, halt_next;
    logic [15:0] stk_reg [RETURN_DEPTH];
    logic        m_valid_reg;
    out_item_t   out_reg, out_next;

    logic        accept;
    in_item_t    d;
    logic [2:0]  src, mid;
    logic [1:0]  rp;
    logic [7:0]  opnd, old8, v8;
    logic [15:0] pv, hl, tgt, pc1, pc2, pc3;
    logic [16:0] dsum;
    logic        cond, push;
    logic [7:0]  alu_b, alu_res;
    logic        alu_cin;
    logic [1:0]  alu_fn;
    logic        alu_use;
    logic [4:0]  alu_f;

    assign accept = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;
    assign d = s_data;

    i8085s_alu u_alu (
        .a(a_reg), .b(alu_b), .cin(alu_cin), .flags_in(f_reg),
        .func(alu_fn), .result(alu_res), .flags_out(alu_f)
    );

    // Operand selection and condition evaluation.
    always_comb begin
        src = d.opcode[2:0];
        mid = d.opcode[5:3];
        rp  = d.opcode[5:4];
        hl  = {r_reg[4], r_reg[5]};
        opnd = (src == REG_A) ? a_reg : (src == REG_M) ? d.read_data : r_reg[src];
        old8 = (mid == REG_A) ? a_reg : (mid == REG_M) ? d.read_data : r_reg[mid];
        pv  = (rp == RP_SP) ? sp_reg : {r_reg[{rp, 1'b0}], r_reg[{rp, 1'b1}]};
        tgt = {d.data_high, d.data_low};
        pc1 = pc_reg + 16'd1;
        pc2 = pc_reg + 16'd2;
        pc3 = pc_reg + 16'd3;
        dsum = {1'b0, hl} + {1'b0, pv};
        unique case (mid)
            3'd0: cond = !f_reg[FL_Z];
            3'd1: cond = f_reg[FL_Z];
            3'd2: cond = !f_reg[FL_CY];
            3'd3: cond = f_reg[FL_CY];
            3'd4: cond = !f_reg[FL_P];
            3'd5: cond = f_reg[FL_P];
            3'd6: cond = !f_reg[FL_S];
            default: cond = f_reg[FL_S];
        endcase
        alu_use = 1'b1;
        alu_b = opnd;
        alu_cin = 1'b0;
        alu_fn = FN_ADD;
        if (d.opcode[7:3] == 5'b10000) begin
            alu_fn = FN_ADD;
        end else if (d.opcode[7:3] == 5'b10001) begin
            alu_cin = f_reg[FL_CY];
        end else if (d.opcode[7:3] == 5'b10100) begin
            alu_fn = FN_AND;
        end else if (d.opcode[7:3] == 5'b10111) begin
            alu_fn = FN_CMP;
        end else if (d.opcode == OP_ADI) begin
            alu_b = d.data_low;
        end else if (d.opcode == OP_ACI) begin
            alu_b = d.data_low;
            alu_cin = f_reg[FL_CY];
        end else if (d.opcode == OP_ANI) begin
            alu_b = d.data_low;
            alu_fn = FN_AND;
        end else if (d.opcode == OP_CPI) begin
            alu_b = d.data_low;
            alu_fn = FN_CMP;
        end else if (d.opcode == OP_DAA) begin
            alu_fn = FN_DAA;
        end else begin
            alu_use = 1'b0;
        end
    end

    // Next architectural state for the accepted instruction.
    always_comb begin
        a_next = a_reg;
        r_next = r_reg;
        sp_next = sp_reg;
        f_next = f_reg;
        pc_next = pc1;
        dep_next = dep_reg;
        halt_next = halt_reg;
        push = 1'b0;
        v8 = (d.opcode[0] == 1'b0) ? old8 + 8'd1 : old8 - 8'd1;
        out_next = '0;
        if (!halt_reg) begin
            if (alu_use) begin
                a_next = alu_res;
                f_next = alu_f;
                if (d.opcode[7:6] == 2'b11) begin
                    pc_next = pc2;
                end
            end else if (d.opcode[7:6] == 2'b00 && d.opcode[2:1] == 2'b10) begin
                if (mid == REG_A) begin
                    a_next = v8;
                end else if (mid == REG_M) begin
                    out_next.mem_write = 1'b1;
                    out_next.mem_write_data = v8;
                end else begin
                    r_next[mid] = v8;
                end
                f_next = szp(v8);
                f_next[FL_AC] = (d.opcode[0] == 1'b0) ? (old8[3:0] == 4'hF)
                                                      : (old8[3:0] != 4'h0);
                f_next[FL_CY] = f_reg[FL_CY];
            end else if (d.opcode[7:6] == 2'b00 && d.opcode[2:0] == 3'b011) begin
                if (rp == RP_SP) begin
                    sp_next = d.opcode[3] ? pv - 16'd1 : pv + 16'd1;
                end else begin
                    {r_next[{rp, 1'b0}], r_next[{rp, 1'b1}]} =
                        d.opcode[3] ? pv - 16'd1 : pv + 16'd1;
                end
            end else if (d.opcode[7:6] == 2'b00 && d.opcode[3:0] == 4'h9) begin
                {r_next[4], r_next[5]} = dsum[15:0];
                f_next[FL_CY] = dsum[16];
            end else if (d.opcode == OP_CMA) begin
                a_next = ~a_reg;
            end else if (d.opcode == OP_CMC) begin
                f_next[FL_CY] = ~f_reg[FL_CY];
            end else if (d.opcode == OP_IN) begin
                a_next = d.read_data;
                pc_next = pc2;
            end else if (d.opcode == OP_LDA) begin
                a_next = d.read_data;
                pc_next = pc3;
            end else if (d.opcode == OP_JMP) begin
                pc_next = tgt;
            end else if (d.opcode[7:6] == 2'b11 && d.opcode[2:0] == 3'b010) begin
                pc_next = cond ? tgt : pc3;
            end else if (d.opcode == OP_CALL
                         || (d.opcode[7:6] == 2'b11 && d.opcode[2:0] == 3'b100)) begin
                pc_next = pc3;
                if (d.opcode == OP_CALL || cond) begin
                    if (dep_reg >= DW'(RETURN_DEPTH)) begin
                        out_next.stack_error = 1'b1;
                    end else begin
                        push = 1'b1;
                        dep_next = dep_reg + DW'(1);
                        pc_next = tgt;
                    end
                end
            end else if (d.opcode == OP_RET) begin
                if (dep_reg == '0) begin
                    out_next.stack_error = 1'b1;
                end else begin
                    dep_next = dep_reg - DW'(1);
                    pc_next = stk_reg[AW'(dep_reg - DW'(1))];
                end
            end else if (d.opcode == OP_HLT) begin
                halt_next = 1'b1;
            end
        end else begin
            pc_next = pc_reg;
        end
        out_next.next_pc = pc_next;
        out_next.acc = a_next;
        out_next.flags = f_next;
        out_next.hl_pair = {r_next[4], r_next[5]};
        out_next.halted = halt_next;
    end

    // Architectural state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            r_reg <= '{default: '0};
            sp_reg <= '0;
            f_reg <= '0;
            pc_reg <= '0;
            dep_reg <= '0;
            halt_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_reg <= a_next;
                r_reg <= r_next;
                sp_reg <= sp_next;
                f_reg <= f_next;
                pc_reg <= pc_next;
                dep_reg <= dep_next;
                halt_reg <= halt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    // Return stack and result payload need no reset.
    always_ff @(posedge aclk) begin
        if (accept && push) begin
            stk_reg[AW'(dep_reg)] <= pc3;
        end
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire
